[sv/i2cms_pkg.sv]
// ============================================================================
// i2cms_pkg: shared types and codes for the I2C master byte sequencer
// Command codes, sequencer phases, configuration indexes and the packed
// words carried on the tick and result channels.
// ============================================================================
`default_nettype none

package i2cms_pkg;

    // Command codes carried in the opcode field
    localparam logic [2:0] OP_START     = 3'd0;
    localparam logic [2:0] OP_STOP      = 3'd1;
    localparam logic [2:0] OP_WRITE     = 3'd2;
    localparam logic [2:0] OP_READ      = 3'd3;
    localparam logic [2:0] OP_WAIT_ACK  = 3'd4;
    localparam logic [2:0] OP_SEND_ACK  = 3'd5;
    localparam logic [2:0] OP_SEND_NACK = 3'd6;

    // Configuration register indexes
    localparam logic CFG_TICKS_PER_UNIT = 1'b0;
    localparam logic CFG_ACK_TIMEOUT    = 1'b1;

    localparam int CFG_WIDTH   = 10;
    localparam int DELAY_WIDTH = 13;   // holds 5 * 1023 - 1

    localparam logic [CFG_WIDTH-1:0] TICKS_PER_UNIT_RESET = 10'd8;
    localparam logic [CFG_WIDTH-1:0] ACK_TIMEOUT_RESET    = 10'd250;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST1,
        PH_ST2,
        PH_SP1,
        PH_SP2,
        PH_WA1,
        PH_WA2,
        PH_POLL,
        PH_WB_D,
        PH_WB_H,
        PH_WB_L,
        PH_RB_L,
        PH_RB_R,
        PH_RB_H,
        PH_AK1,
        PH_AK2
    } phase_t;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] opcode;
        logic [7:0] write_data;
        logic       ack_after_read;
        logic       sda_line;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_timed_out;
    } result_t;

endpackage

`default_nettype wire

[sv/i2c_master_byte_sequencer.sv]
// ============================================================================
// i2c_master_byte_sequencer: pin-level I2C master, one tick per word
// Sequences START, STOP, byte write, byte read with ACK/NACK, ACK wait
// with timeout and lone ACK/NACK onto SCL/SDA pin levels.
// ============================================================================
// Usage notes:
//  - Each word on the item channel is one bus tick. It may carry a command
//    (cmd_valid) which is taken only while idle; sda_line is the sampled bus.
//  - Every accepted word yields exactly one result word: the pin levels,
//    busy, a one-tick done pulse, the received byte (on the done tick of a
//    read) and the ACK timeout flag (on the done tick of an ACK wait).
//  - The result is registered: a word accepted at one edge appears on the
//    result channel after that edge. Throughput is one word per cycle while
//    the result channel does not stall; the whole phase update is a single
//    pass from the state registers to the result register.
//  - The result register decouples the channels: a new word is taken while
//    the held result is being taken; if the receiver stalls with a result
//    held, item_stall rises and the sequencer state is frozen.
//  - Reset: idle, SCL and SDA high and driven, counters cleared, registers at
//    8 ticks per unit and 250 ticks of ACK timeout. The user must write
//    cfg_write/cfg_index/cfg_data only while idle; the block does not check.
// ============================================================================
`default_nettype none

module i2c_master_byte_sequencer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // tick channel
    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire i2cms_pkg::item_t               item,
    // result channel
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output i2cms_pkg::result_t                  result,
    // configuration
    input  wire logic                           cfg_write,
    input  wire logic                           cfg_index,
    input  wire logic [i2cms_pkg::CFG_WIDTH-1:0] cfg_data
);

    localparam int DW = i2cms_pkg::DELAY_WIDTH;

    // configuration registers
    logic [i2cms_pkg::CFG_WIDTH-1:0] ticks_per_unit_reg;
    logic [i2cms_pkg::CFG_WIDTH-1:0] ack_timeout_reg;

    // sequencer state
    i2cms_pkg::phase_t phase_reg, phase_next;
    logic [2:0]        active_op_reg, active_op_next;
    logic [3:0]        bit_count_reg, bit_count_next;
    logic [DW-1:0]     delay_count_reg, delay_count_next;
    logic [7:0]        shift_reg, shift_next;
    logic [i2cms_pkg::CFG_WIDTH-1:0] wait_count_reg, wait_count_next;
    logic              ack_choice_reg, ack_choice_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic              oe_reg, oe_next;

    // result register
    logic               result_valid_reg;
    i2cms_pkg::result_t result_reg, result_next;

    logic          accept;
    logic          done_flag;
    logic          tout_flag;
    logic [DW-1:0] unit;
    logic [DW-1:0] d1, d2, d4, d5, d5m2;

    assign item_stall   = result_valid_reg & result_stall;
    assign accept       = item_valid & ~item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // phase lengths minus one; zero ticks per unit counts as one
    always_comb
    begin
        unit = (ticks_per_unit_reg == '0) ? DW'(1) : DW'(ticks_per_unit_reg);
        d1   = unit - DW'(1);
        d2   = (unit << 1) - DW'(1);
        d4   = (unit << 2) - DW'(1);
        d5   = (unit << 2) + unit - DW'(1);
        d5m2 = (unit << 2) + unit - DW'(2);
    end

    // one tick of the sequencer
    always_comb
    begin
        phase_next       = phase_reg;
        active_op_next   = active_op_reg;
        bit_count_next   = bit_count_reg;
        delay_count_next = delay_count_reg;
        shift_next       = shift_reg;
        wait_count_next  = wait_count_reg;
        ack_choice_next  = ack_choice_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        oe_next          = oe_reg;
        done_flag        = 1'b0;
        tout_flag        = 1'b0;

        if (phase_reg == i2cms_pkg::PH_IDLE)
        begin
            if (item.cmd_valid)
            begin
                case (item.opcode)
                    i2cms_pkg::OP_START:
                    begin
                        active_op_next   = item.opcode;
                        oe_next          = 1'b1;
                        sda_next         = 1'b1;
                        scl_next         = 1'b1;
                        phase_next       = i2cms_pkg::PH_ST1;
                        delay_count_next = d2;
                    end
                    i2cms_pkg::OP_STOP:
                    begin
                        active_op_next   = item.opcode;
                        oe_next          = 1'b1;
                        scl_next         = 1'b0;
                        sda_next         = 1'b0;
                        phase_next       = i2cms_pkg::PH_SP1;
                        delay_count_next = d2;
                    end
                    i2cms_pkg::OP_WRITE:
                    begin
                        active_op_next   = item.opcode;
                        oe_next          = 1'b1;
                        scl_next         = 1'b0;
                        bit_count_next   = '0;
                        sda_next         = item.write_data[7];
                        shift_next       = {item.write_data[6:0], 1'b0};
                        phase_next       = i2cms_pkg::PH_WB_D;
                        delay_count_next = d5;
                    end
                    i2cms_pkg::OP_READ:
                    begin
                        active_op_next   = item.opcode;
                        oe_next          = 1'b0;
                        scl_next         = 1'b0;
                        shift_next       = '0;
                        bit_count_next   = '0;
                        ack_choice_next  = item.ack_after_read;
                        phase_next       = i2cms_pkg::PH_RB_L;
                        delay_count_next = d5;
                    end
                    i2cms_pkg::OP_WAIT_ACK:
                    begin
                        active_op_next   = item.opcode;
                        oe_next          = 1'b0;
                        sda_next         = 1'b1;
                        wait_count_next  = '0;
                        phase_next       = i2cms_pkg::PH_WA1;
                        delay_count_next = d1;
                    end
                    i2cms_pkg::OP_SEND_ACK,
                    i2cms_pkg::OP_SEND_NACK:
                    begin
                        active_op_next   = item.opcode;
                        ack_choice_next  = (item.opcode == i2cms_pkg::OP_SEND_ACK);
                        scl_next         = 1'b0;
                        oe_next          = 1'b1;
                        sda_next         = (item.opcode != i2cms_pkg::OP_SEND_ACK);
                        phase_next       = i2cms_pkg::PH_AK1;
                        delay_count_next = d4;
                    end
                    default:
                    begin
                        // undefined opcode: stay idle
                    end
                endcase
            end
        end
        else if (delay_count_reg != '0)
        begin
            delay_count_next = delay_count_reg - DW'(1);
        end
        else
        begin
            case (phase_reg)
                i2cms_pkg::PH_ST1:
                begin
                    sda_next         = 1'b0;
                    phase_next       = i2cms_pkg::PH_ST2;
                    delay_count_next = d2;
                end
                i2cms_pkg::PH_ST2:
                begin
                    scl_next         = 1'b0;
                    done_flag        = 1'b1;
                    phase_next       = i2cms_pkg::PH_IDLE;
                    delay_count_next = '0;
                end
                i2cms_pkg::PH_SP1:
                begin
                    scl_next         = 1'b1;
                    sda_next         = 1'b1;
                    phase_next       = i2cms_pkg::PH_SP2;
                    delay_count_next = d2;
                end
                i2cms_pkg::PH_SP2:
                begin
                    // a stop issued by an ACK wait marks the timeout
                    done_flag        = 1'b1;
                    tout_flag        = (active_op_reg == i2cms_pkg::OP_WAIT_ACK);
                    phase_next       = i2cms_pkg::PH_IDLE;
                    delay_count_next = '0;
                end
                i2cms_pkg::PH_WA1:
                begin
                    scl_next         = 1'b1;
                    phase_next       = i2cms_pkg::PH_WA2;
                    delay_count_next = d1;
                end
                i2cms_pkg::PH_WA2,
                i2cms_pkg::PH_POLL:
                begin
                    phase_next       = i2cms_pkg::PH_POLL;
                    delay_count_next = '0;
                    if (!item.sda_line)
                    begin
                        scl_next       = 1'b0;
                        active_op_next = i2cms_pkg::OP_START;
                        done_flag      = 1'b1;
                        phase_next     = i2cms_pkg::PH_IDLE;
                    end
                    else if (wait_count_reg >= ack_timeout_reg)
                    begin
                        oe_next          = 1'b1;
                        scl_next         = 1'b0;
                        sda_next         = 1'b0;
                        phase_next       = i2cms_pkg::PH_SP1;
                        delay_count_next = d2;
                    end
                    else
                    begin
                        wait_count_next = wait_count_reg + 1'b1;
                    end
                end
                i2cms_pkg::PH_WB_D:
                begin
                    scl_next         = 1'b1;
                    phase_next       = i2cms_pkg::PH_WB_H;
                    delay_count_next = d5;
                end
                i2cms_pkg::PH_WB_H:
                begin
                    scl_next         = 1'b0;
                    phase_next       = i2cms_pkg::PH_WB_L;
                    delay_count_next = d5;
                end
                i2cms_pkg::PH_WB_L:
                begin
                    bit_count_next = bit_count_reg + 1'b1;
                    if (bit_count_next[3])
                    begin
                        done_flag        = 1'b1;
                        phase_next       = i2cms_pkg::PH_IDLE;
                        delay_count_next = '0;
                    end
                    else
                    begin
                        sda_next         = shift_reg[7];
                        shift_next       = {shift_reg[6:0], 1'b0};
                        phase_next       = i2cms_pkg::PH_WB_D;
                        delay_count_next = d5;
                    end
                end
                i2cms_pkg::PH_RB_L:
                begin
                    scl_next         = 1'b1;
                    phase_next       = i2cms_pkg::PH_RB_R;
                    delay_count_next = '0;
                end
                i2cms_pkg::PH_RB_R:
                begin
                    // sample one tick after SCL rises
                    shift_next       = {shift_reg[6:0], item.sda_line};
                    phase_next       = i2cms_pkg::PH_RB_H;
                    delay_count_next = d5m2;
                end
                i2cms_pkg::PH_RB_H:
                begin
                    bit_count_next = bit_count_reg + 1'b1;
                    if (bit_count_next[3])
                    begin
                        scl_next         = 1'b0;
                        oe_next          = 1'b1;
                        sda_next         = ~ack_choice_reg;
                        phase_next       = i2cms_pkg::PH_AK1;
                        delay_count_next = d4;
                    end
                    else
                    begin
                        scl_next         = 1'b0;
                        phase_next       = i2cms_pkg::PH_RB_L;
                        delay_count_next = d5;
                    end
                end
                i2cms_pkg::PH_AK1:
                begin
                    scl_next         = 1'b1;
                    phase_next       = i2cms_pkg::PH_AK2;
                    delay_count_next = d4;
                end
                i2cms_pkg::PH_AK2:
                begin
                    scl_next         = 1'b0;
                    done_flag        = 1'b1;
                    phase_next       = i2cms_pkg::PH_IDLE;
                    delay_count_next = '0;
                end
                default:
                begin
                    phase_next       = i2cms_pkg::PH_IDLE;
                    delay_count_next = '0;
                end
            endcase
        end

        result_next.scl_level        = scl_next;
        result_next.sda_level        = sda_next;
        result_next.sda_drive_enable = oe_next;
        result_next.busy_res         = (phase_next != i2cms_pkg::PH_IDLE);
        result_next.done_res         = done_flag;
        result_next.read_byte        =
            (done_flag && active_op_next == i2cms_pkg::OP_READ) ? shift_next : 8'h00;
        result_next.ack_timed_out    = tout_flag;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_unit_reg <= i2cms_pkg::TICKS_PER_UNIT_RESET;
            ack_timeout_reg    <= i2cms_pkg::ACK_TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == i2cms_pkg::CFG_TICKS_PER_UNIT)
            begin
                ticks_per_unit_reg <= cfg_data;
            end
            else
            begin
                ack_timeout_reg <= cfg_data;
            end
        end
    end

    // sequencer state, advanced once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= i2cms_pkg::PH_IDLE;
            active_op_reg   <= '0;
            bit_count_reg   <= '0;
            delay_count_reg <= '0;
            shift_reg       <= '0;
            wait_count_reg  <= '0;
            ack_choice_reg  <= 1'b0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            oe_reg          <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            active_op_reg   <= active_op_next;
            bit_count_reg   <= bit_count_next;
            delay_count_reg <= delay_count_next;
            shift_reg       <= shift_next;
            wait_count_reg  <= wait_count_next;
            ack_choice_reg  <= ack_choice_next;
            scl_reg         <= scl_next;
            sda_reg         <= sda_next;
            oe_reg          <= oe_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire
